[src/i2cmts_pkg.sv]
// Types and codes shared by the I2C master transaction sequencer.
// No dependencies.
package i2cmts_pkg;

  typedef logic [3:0] action_t;

  localparam action_t ACT_WRITE     = 4'd0;
  localparam action_t ACT_REG_WRITE = 4'd1;
  localparam action_t ACT_READ      = 4'd2;
  localparam action_t ACT_REG_READ  = 4'd3;
  localparam action_t ACT_START     = 4'd4;
  localparam action_t ACT_ADDR_ACK  = 4'd5;
  localparam action_t ACT_TX_DONE   = 4'd6;
  localparam action_t ACT_RX_DONE   = 4'd7;
  localparam action_t ACT_NACK      = 4'd8;
  localparam action_t ACT_BUS_ERR   = 4'd9;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_START = 4'd1,
    CMD_ADDR  = 4'd2,
    CMD_REG   = 4'd3,
    CMD_TX    = 4'd4,
    CMD_RX    = 4'd5,
    CMD_ABORT = 4'd6,
    CMD_STOP  = 4'd7,
    CMD_RESET = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START     = 3'd1,
    PH_SEND_ADDR = 3'd2,
    PH_SEND_REG  = 3'd3,
    PH_RESTART   = 3'd4,
    PH_SEND_DATA = 3'd5,
    PH_RECV_DATA = 3'd6
  } phase_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NACK = 2'd1;
  localparam logic [1:0] ERR_BUS  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_BUSY = 1'b1;

  localparam logic [7:0] DIR_WRITE_MASK = 8'hFE;
  localparam logic [7:0] DIR_READ_BIT   = 8'h01;

  typedef struct packed {
    action_t     action;
    logic [7:0]  target_address;
    logic [31:0] register_address;
    logic [2:0]  register_address_bytes;
    logic [31:0] buffer_base;
    logic [15:0] transfer_length;
  } item_t;

  typedef struct packed {
    logic        locked;
    phase_t      phase;
    logic        is_read;
    logic        reg_pending;
    logic [7:0]  saved_target;
    logic [31:0] saved_reg_addr;
    logic [2:0]  saved_reg_count;
    logic [31:0] saved_buffer;
    logic [15:0] saved_length;
    logic [1:0]  last_error;
  } state_t;

  typedef struct packed {
    logic        status;
    cmd_t        command;
    logic [7:0]  bus_byte;
    logic [31:0] register_bytes_packed;
    logic [31:0] transfer_address;
    logic [15:0] transfer_count;
    logic        acknowledge_bytes;
    logic [1:0]  error_code;
    logic        busy_res;
  } result_t;

endpackage

[src/i2c_master_transaction_sequencer.sv]
// I2C master transaction sequencer, top level: input register, decode, result register.
// A transaction passes the input stage and then the result stage before its result can
// leave; out_tvalid rises once the decoded item is loaded into the result register.
// Throughput: one transaction per cycle while out_tready stays high; the decode step is combinational.
// Reset (rst_n low, synchronous): bus lock, phase and saved operands cleared, no
// transaction held in either stage.
// Depends on i2cmts_pkg and i2cmts_step.
module i2c_master_transaction_sequencer #(
  parameter int MAX_REGISTER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] target_address, [39:8] register_address, [42:40] register_address_bytes,
  // [74:43] buffer_base, [90:75] transfer_length, [95:91] zero
  input  logic [95:0] in_tdata,
  // [3:0] action
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] bus_byte, [39:8] register_bytes_packed, [71:40] transfer_address,
  // [87:72] transfer_count, [88] acknowledge_bytes, [90:89] error_code,
  // [91] busy_res, [95:92] zero
  output logic [95:0] out_tdata,
  // [0] status, [4:1] command
  output logic [4:0]  out_tuser
);

  i2cmts_pkg::item_t   item_r;
  logic                in_valid_r;
  i2cmts_pkg::state_t  st_r;
  i2cmts_pkg::state_t  st_nxt;
  i2cmts_pkg::result_t res_r;
  i2cmts_pkg::result_t res_nxt;
  logic                out_valid_r;
  logic                out_free;
  logic                advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  i2cmts_step #(
    .MAX_REGISTER_BYTES(MAX_REGISTER_BYTES)
  ) u_step (
    .item  (item_r),
    .st    (st_r),
    .st_nxt(st_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action                 <= in_tuser;
      item_r.target_address         <= in_tdata[7:0];
      item_r.register_address       <= in_tdata[39:8];
      item_r.register_address_bytes <= in_tdata[42:40];
      item_r.buffer_base            <= in_tdata[74:43];
      item_r.transfer_length        <= in_tdata[90:75];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.command, res_r.status};
  assign out_tdata  = {4'h0, res_r.busy_res, res_r.error_code, res_r.acknowledge_bytes,
                       res_r.transfer_count, res_r.transfer_address,
                       res_r.register_bytes_packed, res_r.bus_byte};

endmodule

[src/i2cmts_step.sv]
// Next-state and command decode for one transaction item.
// Depends on i2cmts_pkg.
module i2cmts_step #(
  parameter int MAX_REGISTER_BYTES = 4
) (
  input  i2cmts_pkg::item_t   item,
  input  i2cmts_pkg::state_t  st,
  output i2cmts_pkg::state_t  st_nxt,
  output i2cmts_pkg::result_t res
);

  localparam logic [2:0] MaxBytes = 3'(MAX_REGISTER_BYTES);

  logic [2:0]  req_count;
  logic [31:0] packed_bytes;

  assign req_count = (item.register_address_bytes > MaxBytes) ? MaxBytes
                                                             : item.register_address_bytes;

  always_comb begin
    unique case (st.saved_reg_count)
      3'd1:    packed_bytes = {st.saved_reg_addr[7:0], 24'h0};
      3'd2:    packed_bytes = {st.saved_reg_addr[15:0], 16'h0};
      3'd3:    packed_bytes = {st.saved_reg_addr[23:0], 8'h0};
      3'd4:    packed_bytes = st.saved_reg_addr;
      default: packed_bytes = 32'h0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.command = i2cmts_pkg::CMD_NONE;
    if (item.action <= i2cmts_pkg::ACT_REG_READ) begin
      if (st.locked) begin
        res.status = i2cmts_pkg::STATUS_BUSY;
      end else begin
        st_nxt.locked          = 1'b1;
        st_nxt.is_read         = (item.action >= i2cmts_pkg::ACT_READ);
        st_nxt.reg_pending     = item.action[0];
        st_nxt.saved_target    = item.target_address;
        st_nxt.saved_reg_addr  = item.register_address;
        st_nxt.saved_reg_count = req_count;
        st_nxt.saved_buffer    = item.buffer_base;
        st_nxt.saved_length    = item.transfer_length;
        st_nxt.last_error      = i2cmts_pkg::ERR_NONE;
        st_nxt.phase           = i2cmts_pkg::PH_START;
        res.command            = i2cmts_pkg::CMD_START;
      end
    end else if (st.locked) begin
      unique case (item.action)
        i2cmts_pkg::ACT_START: begin
          if (st.phase == i2cmts_pkg::PH_START || st.phase == i2cmts_pkg::PH_RESTART) begin
            if (!st.is_read || st.reg_pending) begin
              res.bus_byte = st.saved_target & i2cmts_pkg::DIR_WRITE_MASK;
            end else begin
              res.bus_byte = st.saved_target | i2cmts_pkg::DIR_READ_BIT;
            end
            st_nxt.phase = i2cmts_pkg::PH_SEND_ADDR;
            res.command  = i2cmts_pkg::CMD_ADDR;
          end
        end
        i2cmts_pkg::ACT_ADDR_ACK: begin
          if (st.phase == i2cmts_pkg::PH_SEND_ADDR) begin
            if (st.reg_pending) begin
              st_nxt.phase              = i2cmts_pkg::PH_SEND_REG;
              res.command               = i2cmts_pkg::CMD_REG;
              res.register_bytes_packed = packed_bytes;
              res.transfer_count        = {13'h0, st.saved_reg_count};
            end else if (!st.is_read) begin
              st_nxt.phase         = i2cmts_pkg::PH_SEND_DATA;
              res.command          = i2cmts_pkg::CMD_TX;
              res.transfer_address = st.saved_buffer;
              res.transfer_count   = st.saved_length;
            end else begin
              st_nxt.phase          = i2cmts_pkg::PH_RECV_DATA;
              res.command           = i2cmts_pkg::CMD_RX;
              res.transfer_address  = st.saved_buffer;
              res.transfer_count    = st.saved_length;
              res.acknowledge_bytes = (st.saved_length >= 16'd2);
            end
          end
        end
        i2cmts_pkg::ACT_TX_DONE: begin
          if (st.phase == i2cmts_pkg::PH_SEND_REG || st.phase == i2cmts_pkg::PH_SEND_DATA) begin
            if (st.last_error == i2cmts_pkg::ERR_NONE &&
                st.phase == i2cmts_pkg::PH_SEND_REG) begin
              st_nxt.reg_pending = 1'b0;
              if (st.is_read) begin
                st_nxt.phase = i2cmts_pkg::PH_RESTART;
                res.command  = i2cmts_pkg::CMD_START;
              end else begin
                st_nxt.phase         = i2cmts_pkg::PH_SEND_DATA;
                res.command          = i2cmts_pkg::CMD_TX;
                res.transfer_address = st.saved_buffer;
                res.transfer_count   = st.saved_length;
              end
            end else begin
              st_nxt.locked = 1'b0;
              st_nxt.phase  = i2cmts_pkg::PH_IDLE;
              res.command   = i2cmts_pkg::CMD_STOP;
            end
          end
        end
        i2cmts_pkg::ACT_RX_DONE: begin
          if (st.phase == i2cmts_pkg::PH_RECV_DATA) begin
            st_nxt.locked = 1'b0;
            st_nxt.phase  = i2cmts_pkg::PH_IDLE;
            res.command   = i2cmts_pkg::CMD_STOP;
          end
        end
        i2cmts_pkg::ACT_NACK: begin
          st_nxt.last_error = i2cmts_pkg::ERR_NACK;
          if (st.phase == i2cmts_pkg::PH_SEND_ADDR) begin
            st_nxt.locked = 1'b0;
            st_nxt.phase  = i2cmts_pkg::PH_IDLE;
            res.command   = i2cmts_pkg::CMD_STOP;
          end else begin
            res.command = i2cmts_pkg::CMD_ABORT;
          end
        end
        i2cmts_pkg::ACT_BUS_ERR: begin
          st_nxt.last_error = i2cmts_pkg::ERR_BUS;
          st_nxt.locked     = 1'b0;
          st_nxt.phase      = i2cmts_pkg::PH_IDLE;
          res.command       = i2cmts_pkg::CMD_RESET;
        end
        default: begin
          res.command = i2cmts_pkg::CMD_NONE;
        end
      endcase
    end
    res.error_code = st_nxt.last_error;
    res.busy_res   = st_nxt.locked;
  end

endmodule

[src/i2cmts_checker.sv]
// Port-level checks for the I2C master transaction sequencer, bound to the top level.
// Depends on i2cmts_pkg.
module i2cmts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [4:0]  out_tuser
);

  a_busy_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == i2cmts_pkg::STATUS_BUSY
    |-> out_tuser[4:1] == i2cmts_pkg::CMD_NONE && out_tdata[91])
    else $error("busy refusal carries a command or shows the bus free");

  a_start_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:1] == i2cmts_pkg::CMD_START
    |-> out_tdata[91] && out_tuser[0] == i2cmts_pkg::STATUS_OK)
    else $error("start issued without holding the bus lock");

  a_reset_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4:1] == i2cmts_pkg::CMD_RESET
    |-> out_tdata[90:89] == i2cmts_pkg::ERR_BUS && !out_tdata[91])
    else $error("bus reset without bus error code or with lock held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (.*);

[tb/sv/i2cmts_scoreboard_pkg.sv]
// Scoreboard for the I2C master transaction sequencer: shadow state and queued commands.
// Predicts the bus command for each accepted transaction and checks every result.
// Depends on i2cmts_pkg.
package i2cmts_scoreboard_pkg;
  import i2cmts_pkg::*;

  localparam int unsigned REG_BYTES_MAX = 4;

  class bus_command_scoreboard;
    state_t  shadow;
    result_t expected_commands[$];
    int      mismatches;

    function new();
      shadow = '0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return expected_commands.size();
    endfunction

    function void release_bus();
      shadow.locked = 1'b0;
      shadow.phase = PH_IDLE;
    endfunction

    function result_t predict_command(item_t it);
      result_t     r;
      logic [31:0] mask;
      int          count;
      r = '0;
      r.command = CMD_NONE;
      if (it.action <= ACT_REG_READ) begin
        if (shadow.locked) begin
          r.status = STATUS_BUSY;
        end else begin
          count = it.register_address_bytes;
          if (count > REG_BYTES_MAX) count = REG_BYTES_MAX;
          shadow.locked = 1'b1;
          shadow.is_read = (it.action >= ACT_READ);
          shadow.reg_pending = it.action[0];
          shadow.saved_target = it.target_address;
          shadow.saved_reg_addr = it.register_address;
          shadow.saved_reg_count = 3'(count);
          shadow.saved_buffer = it.buffer_base;
          shadow.saved_length = it.transfer_length;
          shadow.last_error = ERR_NONE;
          shadow.phase = PH_START;
          r.command = CMD_START;
        end
      end else if (shadow.locked) begin
        case (it.action)
          ACT_START: begin
            if (shadow.phase == PH_START || shadow.phase == PH_RESTART) begin
              if (!shadow.is_read || shadow.reg_pending)
                r.bus_byte = shadow.saved_target & DIR_WRITE_MASK;
              else
                r.bus_byte = shadow.saved_target | DIR_READ_BIT;
              shadow.phase = PH_SEND_ADDR;
              r.command = CMD_ADDR;
            end
          end
          ACT_ADDR_ACK: begin
            if (shadow.phase == PH_SEND_ADDR) begin
              if (shadow.reg_pending) begin
                count = shadow.saved_reg_count;
                shadow.phase = PH_SEND_REG;
                r.command = CMD_REG;
                r.transfer_count = 16'(count);
                if (count >= 4) begin
                  r.register_bytes_packed = shadow.saved_reg_addr;
                end else if (count > 0) begin
                  mask = (32'd1 << (8 * count)) - 32'd1;
                  r.register_bytes_packed = (shadow.saved_reg_addr & mask) << (8 * (4 - count));
                end
              end else if (!shadow.is_read) begin
                shadow.phase = PH_SEND_DATA;
                r.command = CMD_TX;
                r.transfer_address = shadow.saved_buffer;
                r.transfer_count = shadow.saved_length;
              end else begin
                shadow.phase = PH_RECV_DATA;
                r.command = CMD_RX;
                r.transfer_address = shadow.saved_buffer;
                r.transfer_count = shadow.saved_length;
                r.acknowledge_bytes = (shadow.saved_length >= 16'd2);
              end
            end
          end
          ACT_TX_DONE: begin
            if (shadow.phase == PH_SEND_REG || shadow.phase == PH_SEND_DATA) begin
              if (shadow.last_error == ERR_NONE && shadow.phase == PH_SEND_REG) begin
                shadow.reg_pending = 1'b0;
                if (shadow.is_read) begin
                  shadow.phase = PH_RESTART;
                  r.command = CMD_START;
                end else begin
                  shadow.phase = PH_SEND_DATA;
                  r.command = CMD_TX;
                  r.transfer_address = shadow.saved_buffer;
                  r.transfer_count = shadow.saved_length;
                end
              end else begin
                release_bus();
                r.command = CMD_STOP;
              end
            end
          end
          ACT_RX_DONE: begin
            if (shadow.phase == PH_RECV_DATA) begin
              release_bus();
              r.command = CMD_STOP;
            end
          end
          ACT_NACK: begin
            shadow.last_error = ERR_NACK;
            if (shadow.phase == PH_SEND_ADDR) begin
              release_bus();
              r.command = CMD_STOP;
            end else begin
              r.command = CMD_ABORT;
            end
          end
          ACT_BUS_ERR: begin
            shadow.last_error = ERR_BUS;
            release_bus();
            r.command = CMD_RESET;
          end
          default: ;
        endcase
      end
      r.error_code = shadow.last_error;
      r.busy_res = shadow.locked;
      return r;
    endfunction

    function void record_action(item_t it);
      expected_commands.push_back(predict_command(it));
    endfunction

    function string describe(result_t r);
      return $sformatf("st %0d cmd %0d byte %h regs %h addr %h cnt %h ack %0d err %0d busy %0d",
                       r.status, r.command, r.bus_byte, r.register_bytes_packed,
                       r.transfer_address, r.transfer_count, r.acknowledge_bytes,
                       r.error_code, r.busy_res);
    endfunction

    function void check_command(result_t got);
      result_t want;
      string   diff;
      if (expected_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = expected_commands.pop_front();
      diff = "";
      if (got.status !== want.status) diff = {diff, " status"};
      if (got.command !== want.command) diff = {diff, " command"};
      if (got.bus_byte !== want.bus_byte) diff = {diff, " bus_byte"};
      if (got.register_bytes_packed !== want.register_bytes_packed)
        diff = {diff, " register_bytes_packed"};
      if (got.transfer_address !== want.transfer_address) diff = {diff, " transfer_address"};
      if (got.transfer_count !== want.transfer_count) diff = {diff, " transfer_count"};
      if (got.acknowledge_bytes !== want.acknowledge_bytes) diff = {diff, " acknowledge_bytes"};
      if (got.error_code !== want.error_code) diff = {diff, " error_code"};
      if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch in%s", diff);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/i2c_master_transaction_sequencer_test.sv]
// Top-level test of the I2C master transaction sequencer: clock, reset, stimulus, monitor.
// Runs directed transactions, then random well-formed and broken ones under four idle and stall mixes.
// Depends on i2cmts_pkg, i2cmts_scoreboard_pkg and the sequencer RTL.
module i2c_master_transaction_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmts_pkg::*;
  import i2cmts_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int LAST_ACTION_CODE = 15;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [4:0]  out_tuser;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int script_items = 0;
  int idle_table[4] = '{0, 72, 0, 22};
  int stall_table[4] = '{0, 0, 72, 22};

  bus_command_scoreboard sb = new();

  i2c_master_transaction_sequencer #(
    .MAX_REGISTER_BYTES(REG_BYTES_MAX)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : monitor
    item_t   it;
    result_t res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        res.status = out_tuser[0];
        res.command = cmd_t'(out_tuser[4:1]);
        res.bus_byte = out_tdata[7:0];
        res.register_bytes_packed = out_tdata[39:8];
        res.transfer_address = out_tdata[71:40];
        res.transfer_count = out_tdata[87:72];
        res.acknowledge_bytes = out_tdata[88];
        res.error_code = out_tdata[90:89];
        res.busy_res = out_tdata[91];
        sb.check_command(res);
      end
      if (in_tvalid && in_tready) begin
        it.action = in_tuser;
        it.target_address = in_tdata[7:0];
        it.register_address = in_tdata[39:8];
        it.register_address_bytes = in_tdata[42:40];
        it.buffer_base = in_tdata[74:43];
        it.transfer_length = in_tdata[90:75];
        sb.record_action(it);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic item_t make_item(input action_t act, input logic [7:0] tgt,
                                      input logic [31:0] raddr, input logic [2:0] nbytes,
                                      input logic [31:0] base, input logic [15:0] len);
    item_t it;
    it.action = act;
    it.target_address = tgt;
    it.register_address = raddr;
    it.register_address_bytes = nbytes;
    it.buffer_base = base;
    it.transfer_length = len;
    return it;
  endfunction

  function automatic item_t random_item(input action_t act);
    logic [15:0] len;
    case ($urandom_range(7))
      0:       len = 16'd0;
      1:       len = 16'd1;
      2:       len = 16'd2;
      3:       len = 16'hFFFF;
      default: len = 16'($urandom);
    endcase
    return make_item(act, 8'($urandom), $urandom, 3'($urandom_range(7)), $urandom, len);
  endfunction

  function automatic action_t random_request();
    return action_t'($urandom_range(ACT_WRITE, ACT_REG_READ));
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, it.transfer_length, it.buffer_base, it.register_address_bytes,
                 it.register_address, it.target_address};
    in_tuser <= it.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    script_items++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_transaction();
    action_t steps[$];
    action_t kind;
    action_t stray;
    int      roll;
    kind = random_request();
    case (kind)
      ACT_WRITE:     steps = {ACT_START, ACT_ADDR_ACK, ACT_TX_DONE};
      ACT_REG_WRITE: steps = {ACT_START, ACT_ADDR_ACK, ACT_TX_DONE, ACT_TX_DONE};
      ACT_READ:      steps = {ACT_START, ACT_ADDR_ACK, ACT_RX_DONE};
      default:       steps = {ACT_START, ACT_ADDR_ACK, ACT_TX_DONE,
                              ACT_START, ACT_ADDR_ACK, ACT_RX_DONE};
    endcase
    send_item(random_item(kind));
    foreach (steps[i]) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_item(random_item(ACT_NACK));
        // a NACK outside the address phase leaves the lock held
        if (steps[i] == ACT_TX_DONE) begin
          send_item(random_item(ACT_TX_DONE));
        end else if (steps[i] != ACT_ADDR_ACK) begin
          repeat ($urandom_range(0, 2)) send_item(random_item(random_request()));
          send_item(random_item(ACT_BUS_ERR));
        end
        return;
      end
      if (roll < 6) begin
        send_item(random_item(ACT_BUS_ERR));
        return;
      end
      if (roll < 9) begin
        send_item(random_item(random_request()));
      end else if (roll < 12) begin
        if ($urandom_range(3) == 0) begin
          stray = action_t'($urandom_range(ACT_BUS_ERR + 1, LAST_ACTION_CODE));
        end else begin
          do stray = action_t'($urandom_range(ACT_START, ACT_RX_DONE));
          while (stray == steps[i]);
        end
        send_item(random_item(stray));
      end
      send_item(random_item(steps[i]));
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_item(make_item(ACT_WRITE, 8'hFF, 32'h0, 3'd0, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_ADDR_ACK));
    send_item(random_item(ACT_TX_DONE));
    send_item(make_item(ACT_REG_WRITE, 8'h00, 32'hFFFF_FFFF, 3'd7, 32'h0, 16'd1));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_ADDR_ACK));
    send_item(random_item(ACT_TX_DONE));
    send_item(random_item(ACT_TX_DONE));
    send_item(make_item(ACT_READ, 8'h00, 32'h0, 3'd4, 32'h1234_5678, 16'd1));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_ADDR_ACK));
    send_item(random_item(ACT_RX_DONE));
    send_item(make_item(ACT_REG_READ, 8'hA5, 32'h1234_5678, 3'd0, 32'h8000_0000, 16'd0));
    send_item(random_item(ACT_READ));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_ADDR_ACK));
    send_item(random_item(ACT_TX_DONE));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_ADDR_ACK));
    send_item(random_item(ACT_RX_DONE));
    send_item(make_item(ACT_WRITE, 8'h5A, 32'hA5A5_A5A5, 3'd2, 32'h0000_FFFF, 16'd2));
    send_item(random_item(ACT_START));
    send_item(random_item(ACT_NACK));
    send_item(random_item(ACT_BUS_ERR));
    send_item(random_item(action_t'(LAST_ACTION_CODE)));
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_table[p];
      recv_stall_pct = stall_table[p];
      while (script_items < RANDOM_ITEMS * (p + 1) / 4) begin
        if ($urandom_range(99) < 30)
          repeat ($urandom_range(1, 2))
            send_item(random_item(action_t'($urandom_range(ACT_START, LAST_ACTION_CODE))));
        run_transaction();
      end
      // hold off until the sequencer has drained
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("i2c_master_transaction_sequencer regression: pass");
    else
      $display("i2c_master_transaction_sequencer regression: fail");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("i2c_master_transaction_sequencer regression: fail");
    $finish;
  end

endmodule
